[design/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg: shared definitions of the finite-difference derivative block
// Register map, interior stencil codes, fixed widths and the result
// metadata that travels beside the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fdd_pkg;

  // Default width of one input sample, signed with 20 fractional bits.
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Fixed widths of the configuration and result fields.
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned MULT_BITS   = 32;
  localparam int unsigned PART_BITS   = 16;
  localparam int unsigned RESULT_BITS = 48;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  // Smallest grid that the block works on.
  localparam logic [INDEX_BITS-1:0] MIN_LAST_INDEX = 16'd4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_LAST_INDEX     = 2'd0;
  localparam logic [1:0] REG_DIFF_MODE      = 2'd1;
  localparam logic [1:0] REG_INV_DX         = 2'd2;
  localparam logic [1:0] REG_INV_DX_SQUARED = 2'd3;

  // Result slots of a job; a final sample runs through all three.
  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_MID   = 2'd1;
  localparam logic [1:0] SLOT_LAST  = 2'd2;

  // Interior stencil; the unused code behaves as centered.
  typedef enum logic [1:0] {
    MODE_CENTERED = 2'd0,
    MODE_BACKWARD = 2'd1,
    MODE_FORWARD  = 2'd2
  } mode_e;

  // Metadata that follows one result through the pipeline.
  typedef struct packed {
    logic [INDEX_BITS-1:0] grid_index;
    logic                  last_result;
  } meta_t;

endpackage : fdd_pkg

`default_nettype wire

[design/fdd_scale.sv]
// ----------------------------------------------------------------------------
// fdd_scale: fixed-point scaling of one difference
// Multiplies a signed difference by an unsigned reciprocal with 8 fractional
// bits in two 16-bit partial products, rounds half away from zero by 2^8 or
// 2^9 and saturates to the signed 48-bit result range. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fdd_scale
  import fdd_pkg::*;
#(
  parameter int unsigned DIFF_BITS = SAMPLE_BITS_DEF + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [DIFF_BITS-1:0]   diff_i,
  input  wire logic        [MULT_BITS-1:0]   mult_i,
  input  wire logic                          half_i,
  output logic signed      [RESULT_BITS-1:0] result_o
);

  localparam int unsigned PP_BITS = DIFF_BITS + PART_BITS + 1;
  localparam int unsigned PW      = DIFF_BITS + MULT_BITS + 1;
  localparam int unsigned XW      = (PW > RESULT_BITS + 1) ? PW : RESULT_BITS + 1;

  localparam logic signed [XW-1:0] POS_LIMIT = XW'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [XW-1:0] NEG_LIMIT = XW'(48'sh8000_0000_0000);
  localparam logic signed [XW-1:0] HALF_K8   = XW'(9'sd128);
  localparam logic signed [XW-1:0] HALF_K9   = XW'(10'sd256);

  logic signed [PP_BITS-1:0] pp_lo_d, pp_hi_d, pp_lo_q, pp_hi_q;
  logic                      neg_q, half_a_q, half_b_q;
  logic signed [XW-1:0]      rnd, sum_d, sum_q, shifted;

  // Partial products of the difference with each half of the reciprocal.
  assign pp_lo_d = diff_i * $signed({1'b0, mult_i[PART_BITS-1:0]});
  assign pp_hi_d = diff_i * $signed({1'b0, mult_i[MULT_BITS-1:PART_BITS]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
      neg_q    <= diff_i[DIFF_BITS-1];
      half_a_q <= half_i;
    end
  end

  // Rounding offset: half of the divisor, one less for negative values,
  // so that the arithmetic shift rounds halves away from zero.
  assign rnd   = (half_a_q ? HALF_K9 : HALF_K8) - XW'($signed({1'b0, neg_q}));
  assign sum_d = (XW'(pp_hi_q) <<< PART_BITS) + XW'(pp_lo_q) + rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= sum_d;
      half_b_q <= half_a_q;
    end
  end

  // Scale down and clamp to the 48-bit range.
  assign shifted = half_b_q ? (sum_q >>> 9) : (sum_q >>> 8);

  always_comb begin
    if (shifted > POS_LIMIT) begin
      result_o = POS_LIMIT[RESULT_BITS-1:0];
    end else if (shifted < NEG_LIMIT) begin
      result_o = NEG_LIMIT[RESULT_BITS-1:0];
    end else begin
      result_o = shifted[RESULT_BITS-1:0];
    end
  end

endmodule : fdd_scale

`default_nettype wire

[design/finite_difference_derivatives.sv]
// ----------------------------------------------------------------------------
// finite_difference_derivatives: streaming first and second derivatives
// Keeps a five-sample window over a grid stream and emits, for each grid
// index, the first and second finite differences scaled by the configured
// reciprocals of dx and dx squared.
//
//  Channel   Direction  Payload (low bits first)
//  s_axis    in         tdata: sample
//  m_axis    out        tdata: grid_index, first_derivative, second_derivative;
//                       tlast: last_result
//  apb       in/out     last_index, difference_mode, inv_dx, inv_dx_squared
//
// One sample is taken per cycle while s_axis is ready. A sample that ends a grid
// yields three results and keeps the input waiting until the last of them
// issues; others yield one or none. A result passes from its sample through the
// job register, difference register, two multiplier stages and output register.
// A stall on m_axis freezes the whole pipeline; s_axis stays ready while the
// job register is free or hands over its last result in that cycle.
// Reset clears the window, the sample count and the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module finite_difference_derivatives
  import fdd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Sample stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, rest zero
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // Result stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] grid_index, [63:16] first_derivative, [111:64] second_derivative
  output logic [INDEX_BITS+2*RESULT_BITS-1:0]     m_axis_tdata,
  output logic                                    m_axis_tlast,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [APB_ADDR_W-1:0]              paddr,
  input  wire logic [APB_DATA_W-1:0]              pwdata,
  output logic [APB_DATA_W-1:0]                   prdata,
  output logic                                    pready
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = SAMPLE_BITS + 2;

  // Configuration registers.
  logic [INDEX_BITS-1:0] last_index_q;
  logic [1:0]            mode_q;
  logic [23:0]           inv_dx_q;
  logic [MULT_BITS-1:0]  inv_dx_sq_q;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= 16'd4;
      mode_q       <= MODE_CENTERED;
      inv_dx_q     <= 24'd256;
      inv_dx_sq_q  <= 32'd256;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_LAST_INDEX:     last_index_q <= pwdata[INDEX_BITS-1:0];
        REG_DIFF_MODE:      mode_q       <= pwdata[1:0];
        REG_INV_DX:         inv_dx_q     <= pwdata[23:0];
        REG_INV_DX_SQUARED: inv_dx_sq_q  <= pwdata;
        default:            last_index_q <= last_index_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_LAST_INDEX:     prdata = {16'b0, last_index_q};
      REG_DIFF_MODE:      prdata = {30'b0, mode_q};
      REG_INV_DX:         prdata = {8'b0, inv_dx_q};
      REG_INV_DX_SQUARED: prdata = inv_dx_sq_q;
      default:            prdata = '0;
    endcase
  end

  // Handshake and pipeline enable.
  logic en, accept, issue, job_done;
  logic m_valid_q;

  logic                 job_v_q, job_final_q;
  logic [1:0]           job_slot_q;
  logic [INDEX_BITS-1:0] job_p_q;
  logic signed [SB-1:0] job_win_q [5];

  assign en            = !m_valid_q || m_axis_tready;
  assign issue         = job_v_q && en;
  assign job_done      = !job_final_q || (job_slot_q == SLOT_LAST);
  assign s_axis_tready = !job_v_q || (en && job_done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sample window and grid position.
  logic signed [SB-1:0]  win_q [5];
  logic signed [SB-1:0]  win_d [5];
  logic [INDEX_BITS-1:0] count_q, n_eff;
  logic                  is_final, has_result;

  assign n_eff      = (last_index_q < MIN_LAST_INDEX) ? MIN_LAST_INDEX : last_index_q;
  assign is_final   = count_q >= n_eff;
  assign has_result = is_final || (count_q >= 16'd2);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[4] = $signed(s_axis_tdata[SB-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        win_q[k] <= '0;
      end
      count_q <= '0;
    end else if (accept) begin
      win_q   <= win_d;
      count_q <= is_final ? '0 : count_q + 16'd1;
    end
  end

  // Job register: one window snapshot, issued as one or three results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q    <= 1'b0;
      job_slot_q <= SLOT_FIRST;
    end else if (accept) begin
      job_v_q    <= has_result;
      job_slot_q <= SLOT_FIRST;
    end else if (issue) begin
      job_v_q    <= !job_done;
      job_slot_q <= job_slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_win_q   <= win_d;
      job_p_q     <= count_q;
      job_final_q <= is_final;
    end
  end

  // Stencil differences; a is the newest sample, e the oldest.
  logic signed [DW-1:0] a_x, b_x, c_x, d_x, e_x;
  logic signed [DW-1:0] ab, bc, cd, bd, ac, s_abc, s_bcd, s_cde;

  assign a_x   = DW'(job_win_q[4]);
  assign b_x   = DW'(job_win_q[3]);
  assign c_x   = DW'(job_win_q[2]);
  assign d_x   = DW'(job_win_q[1]);
  assign e_x   = DW'(job_win_q[0]);
  assign ab    = a_x - b_x;
  assign bc    = b_x - c_x;
  assign cd    = c_x - d_x;
  assign bd    = b_x - d_x;
  assign ac    = a_x - c_x;
  assign s_abc = a_x - (b_x <<< 1) + c_x;
  assign s_bcd = b_x - (c_x <<< 1) + d_x;
  assign s_cde = c_x - (d_x <<< 1) + e_x;

  // Stencil selection for the current slot of the job.
  logic signed [DW-1:0] sel_d1, sel_d2;
  logic                 sel_half;
  meta_t                sel_meta;
  logic                 near_start;

  assign near_start = (job_p_q == 16'd2) || (job_p_q == 16'd3);

  always_comb begin
    sel_half            = 1'b0;
    sel_meta.grid_index = job_p_q - 16'd2 + {14'b0, job_slot_q};
    sel_meta.last_result = 1'b0;
    sel_d1              = bc;
    sel_d2              = s_abc;
    if (!job_final_q) begin
      // Result for index p-2 inside the grid.
      if (job_p_q != 16'd2) begin
        case (mode_q)
          MODE_FORWARD:  sel_d1 = bc;
          MODE_BACKWARD: sel_d1 = cd;
          default: begin
            sel_d1   = bd;
            sel_half = 1'b1;
          end
        endcase
      end
      if (!near_start) begin
        case (mode_q)
          MODE_FORWARD:  sel_d2 = s_abc;
          MODE_BACKWARD: sel_d2 = s_cde;
          default:       sel_d2 = s_bcd;
        endcase
      end
    end else begin
      case (job_slot_q)
        // Index n-2: interior first and second differences.
        SLOT_FIRST: begin
          case (mode_q)
            MODE_FORWARD: begin
              sel_d1 = bc;
              sel_d2 = s_abc;
            end
            MODE_BACKWARD: begin
              sel_d1 = cd;
              sel_d2 = s_cde;
            end
            default: begin
              sel_d1   = bd;
              sel_d2   = s_bcd;
              sel_half = 1'b1;
            end
          endcase
        end
        // Index n-1: interior first difference, backward second difference.
        SLOT_MID: begin
          case (mode_q)
            MODE_FORWARD:  sel_d1 = ab;
            MODE_BACKWARD: sel_d1 = bc;
            default: begin
              sel_d1   = ac;
              sel_half = 1'b1;
            end
          endcase
          sel_d2 = s_bcd;
        end
        // Index n: backward stencils, end of grid.
        default: begin
          sel_d1               = ab;
          sel_d2               = s_abc;
          sel_meta.last_result = 1'b1;
        end
      endcase
    end
  end

  // Difference register and metadata pipeline.
  logic signed [DW-1:0] d1_q, d2_q;
  logic                 half_q;
  logic                 v1_q, v2_q, v3_q;
  meta_t                meta1_q, meta2_q, meta3_q, meta_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      v1_q      <= job_v_q;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      m_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q       <= sel_d1;
      d2_q       <= sel_d2;
      half_q     <= sel_half;
      meta1_q    <= sel_meta;
      meta2_q    <= meta1_q;
      meta3_q    <= meta2_q;
      meta_out_q <= meta3_q;
    end
  end

  // Scaling by the reciprocals.
  logic signed [RESULT_BITS-1:0] der1, der2, der1_q, der2_q;

  fdd_scale #(
    .DIFF_BITS (DW)
  ) u_scale_first (
    .clk_i    (clk_i),
    .en_i     (en),
    .diff_i   (d1_q),
    .mult_i   ({8'b0, inv_dx_q}),
    .half_i   (half_q),
    .result_o (der1)
  );

  fdd_scale #(
    .DIFF_BITS (DW)
  ) u_scale_second (
    .clk_i    (clk_i),
    .en_i     (en),
    .diff_i   (d2_q),
    .mult_i   (inv_dx_sq_q),
    .half_i   (1'b0),
    .result_o (der2)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      der1_q <= der1;
      der2_q <= der2;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {der2_q, der1_q, meta_out_q.grid_index};
  assign m_axis_tlast  = meta_out_q.last_result;

  // The input is only ready when the job register can hand over its work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!job_v_q || en))
    else $error("input ready while a pending job is stalled");

  // A job never runs past its third slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_v_q |-> (job_slot_q == SLOT_FIRST || job_slot_q == SLOT_MID ||
                 job_slot_q == SLOT_LAST))
    else $error("job slot out of range");

  // Only grid-ending jobs run beyond their first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_v_q && job_slot_q != SLOT_FIRST) |-> job_final_q)
    else $error("non-final job issued more than one result");

  // The last slot of a grid-ending job marks its result as end of grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && job_final_q && job_slot_q == SLOT_LAST) |=> (v1_q && meta1_q.last_result))
    else $error("end-of-grid result not marked");

endmodule : finite_difference_derivatives

`default_nettype wire

[tb/finite_difference_derivatives_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_difference_derivatives_tb: self-checking bench for the derivative block
// Streams grid samples through the block under many register settings, works
// out every first and second derivative result in a scoreboard of its own, and
// compares each result leaving the block with the oldest prediction. Both
// stream sides stall at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module finite_difference_derivatives_tb;
  import fdd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned PIPE_SLACK     = 12;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned QUIET_PHASES   = 3;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned REPORT_LIMIT   = 20;

  // The unused stencil code, which the block treats as centered.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;

  // One derivative result as it appears on the output stream.
  typedef struct {
    logic [INDEX_BITS-1:0]  grid_index;
    logic [RESULT_BITS-1:0] first_deriv;
    logic [RESULT_BITS-1:0] second_deriv;
    logic                   grid_end;
  } deriv_result_t;

  // Predicts the derivative results of every accepted sample and checks the
  // results leaving the block against them in order.
  class deriv_scoreboard;
    bit [INDEX_BITS-1:0] last_index;
    bit [1:0]            diff_mode;
    bit [23:0]           inv_dx;
    bit [31:0]           inv_dx_sq;
    longint              window[5];
    bit [INDEX_BITS-1:0] sample_count;
    deriv_result_t       expected_q[$];
    int                  errors;
    int                  results_checked;
    int                  grids_closed;

    function new();
      last_index      = MIN_LAST_INDEX;
      diff_mode       = MODE_CENTERED;
      inv_dx          = 24'd256;
      inv_dx_sq       = 32'd256;
      foreach (window[k]) window[k] = 0;
      sample_count    = '0;
      errors          = 0;
      results_checked = 0;
      grids_closed    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_LAST_INDEX:     last_index = value[INDEX_BITS-1:0];
        REG_DIFF_MODE:      diff_mode  = value[1:0];
        REG_INV_DX:         inv_dx     = value[23:0];
        REG_INV_DX_SQUARED: inv_dx_sq  = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Grid value j while the newest sample has index p; older ones read zero.
    function longint window_at(int j, int p);
      if (j > p || p - j > 4) return 0;
      return window[4 - (p - j)];
    endfunction

    // Rounds d*m/2^k to nearest, halves away from zero, and saturates.
    function logic [RESULT_BITS-1:0] scale_to_result(longint d, longint unsigned m, int k);
      bit              neg;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned limit;
      bit [63:0]       r;
      neg   = (d < 0);
      mag   = neg ? -d : d;
      q     = (mag * m + (64'd1 << (k - 1))) >> k;
      limit = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
      if (q > limit) q = limit;
      r = neg ? (64'd0 - q) : q;
      return r[RESULT_BITS-1:0];
    endfunction

    // Result for grid index i of a grid ending at n, newest sample p.
    function deriv_result_t form_result(int i, int n, int p);
      deriv_result_t res;
      longint        d1;
      longint        d2;
      int            k1;
      k1 = 8;
      // First derivative: fixed one-sided stencils at both ends.
      if (i == 0) begin
        d1 = window_at(1, p) - window_at(0, p);
      end else if (i == n) begin
        d1 = window_at(n, p) - window_at(n - 1, p);
      end else if (diff_mode == MODE_FORWARD) begin
        d1 = window_at(i + 1, p) - window_at(i, p);
      end else if (diff_mode == MODE_BACKWARD) begin
        d1 = window_at(i, p) - window_at(i - 1, p);
      end else begin
        d1 = window_at(i + 1, p) - window_at(i - 1, p);
        k1 = 9;
      end
      // Second derivative: two fixed stencils at each end of the grid.
      if (i == 0) begin
        d2 = window_at(2, p) - 2 * window_at(1, p) + window_at(0, p);
      end else if (i == 1) begin
        d2 = window_at(3, p) - 2 * window_at(2, p) + window_at(1, p);
      end else if (i == n - 1) begin
        d2 = window_at(n - 1, p) - 2 * window_at(n - 2, p) + window_at(n - 3, p);
      end else if (i == n) begin
        d2 = window_at(n, p) - 2 * window_at(n - 1, p) + window_at(n - 2, p);
      end else if (diff_mode == MODE_FORWARD) begin
        d2 = window_at(i + 2, p) - 2 * window_at(i + 1, p) + window_at(i, p);
      end else if (diff_mode == MODE_BACKWARD) begin
        d2 = window_at(i, p) - 2 * window_at(i - 1, p) + window_at(i - 2, p);
      end else begin
        d2 = window_at(i + 1, p) - 2 * window_at(i, p) + window_at(i - 1, p);
      end
      res.grid_index   = i[INDEX_BITS-1:0];
      res.first_deriv  = scale_to_result(d1, 64'(inv_dx), k1);
      res.second_deriv = scale_to_result(d2, 64'(inv_dx_sq), 8);
      res.grid_end     = (i == n);
      return res;
    endfunction

    // Takes one accepted sample request and queues the results it causes.
    function void note_sample(logic [23:0] raw);
      int     n;
      int     p;
      longint value;
      value = longint'($signed(raw));
      for (int k = 0; k < 4; k++) window[k] = window[k + 1];
      window[4] = value;
      n = int'(last_index);
      if (n < int'(MIN_LAST_INDEX)) n = int'(MIN_LAST_INDEX);
      p = int'(sample_count);
      // A sample at or past the end closes the grid with three results.
      if (p >= n) begin
        expected_q.push_back(form_result(p - 2, p, p));
        expected_q.push_back(form_result(p - 1, p, p));
        expected_q.push_back(form_result(p, p, p));
        sample_count = '0;
        grids_closed++;
      end else begin
        sample_count = sample_count + 16'd1;
        if (p >= 2) expected_q.push_back(form_result(p - 2, n, p));
      end
    endfunction

    function void report_mismatch(string field, logic [RESULT_BITS-1:0] want,
                                  logic [RESULT_BITS-1:0] got);
      if (errors < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
      errors++;
    endfunction

    function void check_result(deriv_result_t got);
      deriv_result_t want;
      if (expected_q.size() == 0) begin
        if (errors < REPORT_LIMIT) begin
          $display("%0t: result for grid index %0d arrived with nothing predicted",
                   $time, got.grid_index);
        end
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.grid_index !== want.grid_index)
        report_mismatch("grid_index", RESULT_BITS'(want.grid_index),
                        RESULT_BITS'(got.grid_index));
      if (got.first_deriv !== want.first_deriv)
        report_mismatch("first_derivative", want.first_deriv, got.first_deriv);
      if (got.second_deriv !== want.second_deriv)
        report_mismatch("second_derivative", want.second_deriv, got.second_deriv);
      if (got.grid_end !== want.grid_end)
        report_mismatch("last_result", RESULT_BITS'(want.grid_end),
                        RESULT_BITS'(got.grid_end));
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  s_axis_tvalid;
  logic                                  s_axis_tready;
  // [23:0] sample
  logic [23:0]                           s_axis_tdata;
  logic                                  m_axis_tvalid;
  logic                                  m_axis_tready;
  // [15:0] grid_index, [63:16] first_derivative, [111:64] second_derivative
  logic [INDEX_BITS+2*RESULT_BITS-1:0]   m_axis_tdata;
  logic                                  m_axis_tlast;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic [APB_ADDR_W-1:0]                 paddr;
  logic [APB_DATA_W-1:0]                 pwdata;
  logic [APB_DATA_W-1:0]                 prdata;
  logic                                  pready;

  deriv_scoreboard board;
  bit              source_idle_on;
  bit              sink_idle_on;
  int              hold_request;
  int              cycle_count = 0;
  int              samples_sent = 0;
  int              settings_written = 0;
  int              long_holds = 0;
  logic [23:0]     trend = '0;

  finite_difference_derivatives dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog against a hung pipeline or a lost result.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, board.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every result request leaving the block is checked against the predictions.
  always @(posedge clk_i) begin : result_monitor
    deriv_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.grid_index   = m_axis_tdata[INDEX_BITS-1:0];
      got.first_deriv  = m_axis_tdata[INDEX_BITS+RESULT_BITS-1:INDEX_BITS];
      got.second_deriv = m_axis_tdata[INDEX_BITS+2*RESULT_BITS-1:INDEX_BITS+RESULT_BITS];
      got.grid_end     = m_axis_tlast;
      board.check_result(got);
    end
  end

  // Result sink: random short stalls, plus one long hold when asked for.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        long_holds++;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
    settings_written++;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] grid_last, input logic [1:0] mode_code,
                           input logic [23:0] dx_recip, input logic [31:0] dx2_recip);
    write_reg(REG_LAST_INDEX, {16'd0, grid_last});
    write_reg(REG_DIFF_MODE, {30'd0, mode_code});
    write_reg(REG_INV_DX, {8'd0, dx_recip});
    write_reg(REG_INV_DX_SQUARED, dx2_recip);
  endtask

  // Offers one sample request, after an optional idle gap, until accepted.
  task automatic send_value(input logic [23:0] value);
    int gap;
    gap = 0;
    if (source_idle_on && $urandom_range(0, 3) == 0) gap = int'($urandom_range(1, 4));
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_sample(value);
    samples_sent++;
  endtask

  // Stops offering, waits for every predicted result, then lets the pipe empty.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // Mostly a slowly varying function, with full-range and extreme values mixed in.
  function automatic logic [23:0] next_sample();
    int pick;
    pick = int'($urandom_range(0, 7));
    if (pick < 5) begin
      trend = 24'(trend + $urandom_range(0, 8191) - 4096);
      return trend;
    end else if (pick == 5) begin
      return 24'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic randomize_registers();
    logic [15:0] grid_last;
    logic [1:0]  mode_code;
    logic [23:0] dx_recip;
    logic [31:0] dx2_recip;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: grid_last = 16'($urandom_range(4, 12));
      6:                grid_last = 16'($urandom_range(0, 3));
      7:                grid_last = 16'hFFFF;
      8:                grid_last = 16'($urandom_range(13, 40));
      default:          grid_last = 16'($urandom);
    endcase
    mode_code = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0:       dx_recip = 24'd256;
      1:       dx_recip = 24'hFFFFFF;
      2:       dx_recip = '0;
      3:       dx_recip = 24'($urandom);
      default: dx_recip = 24'($urandom_range(1, 1023));
    endcase
    case ($urandom_range(0, 4))
      0:       dx2_recip = 32'd256;
      1:       dx2_recip = 32'hFFFF_FFFF;
      2:       dx2_recip = '0;
      3:       dx2_recip = $urandom;
      default: dx2_recip = $urandom_range(1, 65535);
    endcase
    write_all(grid_last, mode_code, dx_recip, dx2_recip);
  endtask

  initial begin : stimulus
    logic [23:0] values[$];
    bit          quiet;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_request  = 0;
    source_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: five-point grid, centered, full-scale samples of both signs and a zero.
    values = '{SAMPLE_MAX, SAMPLE_MIN, 24'h000000, SAMPLE_MAX, SAMPLE_MIN};
    foreach (values[k]) send_value(values[k]);
    drain_results();

    // Short grid setting, backward stencil, largest reciprocals: saturation.
    write_all(16'd2, MODE_BACKWARD, 24'hFFFFFF, 32'hFFFF_FFFF);
    values = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
    foreach (values[k]) send_value(values[k]);
    drain_results();

    // Forward stencil; halving reciprocals put odd differences on rounding halves.
    write_all(16'd6, MODE_FORWARD, 24'd128, 32'd128);
    values = '{24'd1, 24'hFFFFFF, 24'd3, 24'hFFFFFD, 24'd5, 24'd2, 24'hFFFFF9};
    foreach (values[k]) send_value(values[k]);
    drain_results();

    // Unused stencil code, zero and tiny reciprocals, bit patterns in the samples.
    write_all(16'd5, MODE_UNUSED, 24'd0, 32'd1);
    values = '{24'h555555, 24'hAAAAAA, 24'h0FF00F, 24'hF00FF0, 24'h123456, 24'hFEDCBA};
    foreach (values[k]) send_value(values[k]);
    drain_results();

    // Random phases; register changes land mid-grid, so grids also end early.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet          = (ph >= RANDOM_PHASES - QUIET_PHASES);
      source_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      sink_idle_on   = !quiet && ($urandom_range(0, 3) != 0);
      randomize_registers();
      // One phase holds the output back long enough to stall the input.
      if (ph == PRESSURE_PHASE) begin
        source_idle_on = 1'b0;
        hold_request   = LONG_HOLD;
      end
      repeat ($urandom_range(20, 40)) send_value(next_sample());
      drain_results();
    end

    $display("Run covered %0d samples over %0d register writes and %0d long output hold(s).",
             samples_sent, settings_written, long_holds);
    $display("Checked %0d derivative results across %0d closed grids, %0d mismatches.",
             board.results_checked, board.grids_closed, board.errors);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
